// File: design/knomial_broadcast_schedule_defines.svh
// Assertion macros for the k-nomial broadcast schedule block.
`ifndef KNOMIAL_BROADCAST_SCHEDULE_DEFINES_SVH
`define KNOMIAL_BROADCAST_SCHEDULE_DEFINES_SVH

// Same-cycle implication, clocked on clk_i, off during reset.
`define KBS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset.
`define KBS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: design/kbs_pkg.sv
// Shared widths, codes and control structs of the k-nomial broadcast schedule block.
package kbs_pkg;

  localparam int RANK_W    = 10;
  localparam int GS_W      = 11;
  localparam int RADIX_W   = 4;
  localparam int KIND_W    = 2;
  localparam int GS_MAX    = (2 ** GS_W) - 1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = GS_W;

  localparam int DEF_MAX_GROUP = 1024;
  localparam int DEF_MAX_RADIX = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_GROUP_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TREE_RADIX = 1'd1;

  localparam logic [GS_W-1:0]    RST_GROUP_SIZE = 11'd1;
  localparam logic [RADIX_W-1:0] RST_TREE_RADIX = 4'd2;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RECV = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEND = 2'd2;
  localparam logic [KIND_W-1:0] KIND_BAD  = 2'd3;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic grow;
    logic grow_stop;
    logic dig_sub;
    logic dig_next;
    logic send_init;
    logic lvl_load;
    logic lvl_dec;
    logic send_next;
    logic emit_bad;
    logic emit_none;
    logic emit_recv;
    logic emit_send;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic bad;
    logic single;
    logic grow_more;
    logic dig_ge;
    logic lvl_zero;
    logic is_root;
    logic recv_last;
    logic has_send;
    logic send_end;
    logic out_free;
  } sts_t;

endpackage

// File: design/kbs_ctrl.sv
// Sequencer for the k-nomial schedule: mask build, digit walk, receive, level sends.
module kbs_ctrl import kbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_GROW  = 3'd2;
  localparam logic [2:0] ST_DIGIT = 3'd3;
  localparam logic [2:0] ST_START = 3'd4;
  localparam logic [2:0] ST_LEVEL = 3'd5;
  localparam logic [2:0] ST_SEND  = 3'd6;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.bad || sts_i.single) begin
          if (sts_i.out_free) begin
            cmd_o.emit_bad  = sts_i.bad;
            cmd_o.emit_none = !sts_i.bad;
            state_d         = ST_IDLE;
          end
        end else begin
          state_d = ST_GROW;
        end
      end
      ST_GROW: begin
        if (sts_i.grow_more) begin
          cmd_o.grow = 1'b1;
        end else begin
          cmd_o.grow_stop = 1'b1;
          state_d         = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (sts_i.dig_ge) begin
          cmd_o.dig_sub = 1'b1;
        end else begin
          cmd_o.dig_next = 1'b1;
          if (sts_i.lvl_zero) state_d = ST_START;
        end
      end
      ST_START: begin
        if (sts_i.is_root) begin
          cmd_o.send_init = 1'b1;
          state_d         = ST_LEVEL;
        end else if (sts_i.out_free) begin
          cmd_o.emit_recv = 1'b1;
          state_d         = sts_i.recv_last ? ST_IDLE : ST_LEVEL;
        end
      end
      ST_LEVEL: begin
        if (sts_i.has_send) begin
          cmd_o.lvl_load = 1'b1;
          state_d        = ST_SEND;
        end else begin
          cmd_o.lvl_dec = 1'b1;
        end
      end
      ST_SEND: begin
        if (sts_i.out_free) begin
          cmd_o.emit_send = 1'b1;
          if (sts_i.send_end) begin
            if (sts_i.lvl_zero) begin
              state_d = ST_IDLE;
            end else begin
              cmd_o.lvl_dec = 1'b1;
              state_d       = ST_LEVEL;
            end
          end else begin
            cmd_o.send_next = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: design/kbs_dp.sv
// Datapath: rank registers, mask table, digit subtractor, peer adders and output register.
module kbs_dp import kbs_pkg::*; #(
  parameter int MAX_GROUP = DEF_MAX_GROUP,
  parameter int MAX_RADIX = DEF_MAX_RADIX
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [GS_W-1:0]     group_size_i,
  input  logic [RADIX_W-1:0]  tree_radix_i,
  input  logic [RANK_W-1:0]   member_rank_i,
  input  logic [RANK_W-1:0]   root_rank_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  output logic [KIND_W-1:0]   action_kind_o,
  output logic [RANK_W-1:0]   peer_rank_o,
  output logic                round_end_o,
  output logic                last_action_o
);

  localparam int SIZE_MAX = (MAX_GROUP < GS_MAX) ? MAX_GROUP : GS_MAX;
  localparam int SZW      = $clog2(SIZE_MAX + 1);
  localparam int KW       = $clog2(MAX_RADIX + 1);
  localparam int PW       = SZW + KW;
  localparam int AW       = ((SZW > RANK_W) ? SZW : RANK_W) + KW + 1;
  localparam int NLVL     = $clog2(SIZE_MAX);
  localparam int IW       = (NLVL > 1) ? $clog2(NLVL) : 1;

  logic [RANK_W-1:0] rank_q, root_q;
  logic [SZW-1:0]    size_q, rel_q, r_q, rb_q, par_q, m_cur_q;
  logic [KW-1:0]     k_q, j_q;
  logic [PW-1:0]     step_q;
  logic [IW-1:0]     lvl_q, top_q, recv_lvl_q;
  logic              bad_q, single_q, nz_q;
  logic [SZW-1:0]    mtab_q [NLVL];

  logic              out_valid_q;
  logic [KIND_W-1:0] kind_q;
  logic [RANK_W-1:0] peer_q;
  logic              rend_q, last_q;

  logic [SZW-1:0]    size_eff, mrd;
  logic [KW-1:0]     k_eff;
  logic [AW-1:0]     rel_full, recv_sum, recv_peer, send_sum, send_peer;
  logic [PW-1:0]     prod;
  logic              bad_in, lvl_zero, send_end, recv_last, out_free;

  // effective configuration, clamped
  always_comb begin
    if (group_size_i == '0) begin
      size_eff = SZW'(1);
    end else if (32'(group_size_i) > 32'(SIZE_MAX)) begin
      size_eff = SZW'(SIZE_MAX);
    end else begin
      size_eff = SZW'(group_size_i);
    end
    if (tree_radix_i < RADIX_W'(2)) begin
      k_eff = KW'(2);
    end else if (32'(tree_radix_i) > 32'(MAX_RADIX)) begin
      k_eff = KW'(MAX_RADIX);
    end else begin
      k_eff = KW'(tree_radix_i);
    end
  end

  assign bad_in = (AW'(member_rank_i) >= AW'(size_eff)) || (AW'(root_rank_i) >= AW'(size_eff));
  assign rel_full = (member_rank_i >= root_rank_i) ?
                    AW'(member_rank_i) - AW'(root_rank_i) :
                    AW'(member_rank_i) + AW'(size_eff) - AW'(root_rank_i);

  assign mrd       = mtab_q[lvl_q];
  assign prod      = PW'(m_cur_q) * PW'(k_q);
  assign lvl_zero  = (lvl_q == '0);
  assign send_end  = (j_q == (k_q - KW'(1))) ||
                     ((AW'(rel_q) + AW'(step_q) + AW'(m_cur_q)) >= AW'(size_q));
  assign recv_last = (recv_lvl_q == '0) || ((AW'(rel_q) + AW'(1)) >= AW'(size_q));
  assign out_free  = !out_valid_q || out_ready_i;

  // peers wrap once around the group
  assign recv_sum  = AW'(par_q) + AW'(root_q);
  assign recv_peer = (recv_sum >= AW'(size_q)) ? recv_sum - AW'(size_q) : recv_sum;
  assign send_sum  = AW'(rank_q) + AW'(step_q);
  assign send_peer = (send_sum >= AW'(size_q)) ? send_sum - AW'(size_q) : send_sum;

  always_comb begin
    sts_o           = '0;
    sts_o.bad       = bad_q;
    sts_o.single    = single_q;
    sts_o.grow_more = prod < PW'(size_q);
    sts_o.dig_ge    = r_q >= mrd;
    sts_o.lvl_zero  = lvl_zero;
    sts_o.is_root   = (rel_q == '0);
    sts_o.recv_last = recv_last;
    sts_o.has_send  = (AW'(rel_q) + AW'(mrd)) < AW'(size_q);
    sts_o.send_end  = send_end;
    sts_o.out_free  = out_free;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rank_q    <= member_rank_i;
      root_q    <= root_rank_i;
      size_q    <= size_eff;
      k_q       <= k_eff;
      bad_q     <= bad_in;
      single_q  <= (size_eff == SZW'(1));
      rel_q     <= rel_full[SZW-1:0];
      m_cur_q   <= SZW'(1);
      lvl_q     <= '0;
      mtab_q[0] <= SZW'(1);
    end
    if (cmd_i.grow) begin
      mtab_q[lvl_q + IW'(1)] <= prod[SZW-1:0];
      m_cur_q                <= prod[SZW-1:0];
      lvl_q                  <= lvl_q + IW'(1);
    end
    if (cmd_i.grow_stop) begin
      top_q <= lvl_q;
      r_q   <= rel_q;
      rb_q  <= rel_q;
      nz_q  <= 1'b0;
    end
    if (cmd_i.dig_sub) begin
      r_q  <= r_q - mrd;
      nz_q <= 1'b1;
    end
    if (cmd_i.dig_next) begin
      // lowest nonzero digit so far: parent clears it
      if (nz_q) begin
        recv_lvl_q <= lvl_q;
        par_q      <= rel_q - rb_q;
      end
      if (!lvl_zero) begin
        lvl_q <= lvl_q - IW'(1);
        rb_q  <= r_q;
        nz_q  <= 1'b0;
      end
    end
    if (cmd_i.send_init) lvl_q <= top_q;
    if (cmd_i.emit_recv) lvl_q <= recv_lvl_q - IW'(1);
    if (cmd_i.lvl_load) begin
      m_cur_q <= mrd;
      step_q  <= PW'(mrd);
      j_q     <= KW'(1);
    end
    if (cmd_i.send_next) begin
      step_q <= step_q + PW'(m_cur_q);
      j_q    <= j_q + KW'(1);
    end
    if (cmd_i.lvl_dec) lvl_q <= lvl_q - IW'(1);

    if (cmd_i.emit_bad) begin
      kind_q <= KIND_BAD;
      peer_q <= '0;
      rend_q <= 1'b0;
      last_q <= 1'b1;
    end
    if (cmd_i.emit_none) begin
      kind_q <= KIND_NONE;
      peer_q <= '0;
      rend_q <= 1'b0;
      last_q <= 1'b1;
    end
    if (cmd_i.emit_recv) begin
      kind_q <= KIND_RECV;
      peer_q <= recv_peer[RANK_W-1:0];
      rend_q <= 1'b0;
      last_q <= recv_last;
    end
    if (cmd_i.emit_send) begin
      kind_q <= KIND_SEND;
      peer_q <= send_peer[RANK_W-1:0];
      rend_q <= send_end;
      last_q <= send_end && lvl_zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_bad || cmd_i.emit_none || cmd_i.emit_recv || cmd_i.emit_send) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_kind_o = kind_q;
  assign peer_rank_o   = peer_q;
  assign round_end_o   = rend_q;
  assign last_action_o = last_q;

endmodule

// File: design/knomial_broadcast_schedule.sv
// After accept: check, mask build over the radix powers below group size, then a digit walk over
//   those levels of the root-relative rank; a non-root first writes its receive word.
// Then one send word per cycle while the output is free, plus a mask load from the table per level.
// Bad input or a group of one: a single word, written from the check state.
// Requests: one at a time; the next is accepted only back in idle, after the last word is written.
// Reset: group_size 1, tree_radix 2, output register empty; no clearing pass.
`include "knomial_broadcast_schedule_defines.svh"
module knomial_broadcast_schedule import kbs_pkg::*; #(
  parameter int MAX_GROUP = DEF_MAX_GROUP,
  parameter int MAX_RADIX = DEF_MAX_RADIX
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // request words
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [RANK_W-1:0]     member_rank_i,
  input  logic [RANK_W-1:0]     root_rank_i,
  // schedule words
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [KIND_W-1:0]     action_kind_o,
  output logic [RANK_W-1:0]     peer_rank_o,
  output logic                  round_end_o,
  output logic                  last_action_o
);

  logic [GS_W-1:0]    group_size_q;
  logic [RADIX_W-1:0] tree_radix_q;
  cmd_t               cmd;
  sts_t               sts;

  // Config registers; raw values are kept and clamped in the datapath at request load.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_size_q <= RST_GROUP_SIZE;
      tree_radix_q <= RST_TREE_RADIX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GROUP_SIZE: group_size_q <= cfg_data_i;
        CFG_TREE_RADIX: tree_radix_q <= cfg_data_i[RADIX_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: check, build masks radix^l, split the relative rank into digits
  // top-down (lowest nonzero digit gives the parent), then walk levels downward.
  kbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: one multiplier for mask growth, one subtractor for digits,
  // wrap adders for peers, and the output word register.
  kbs_dp #(
    .MAX_GROUP (MAX_GROUP),
    .MAX_RADIX (MAX_RADIX)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .group_size_i  (group_size_q),
    .tree_radix_i  (tree_radix_q),
    .member_rank_i (member_rank_i),
    .root_rank_i   (root_rank_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .action_kind_o (action_kind_o),
    .peer_rank_o   (peer_rank_o),
    .round_end_o   (round_end_o),
    .last_action_o (last_action_o)
  );

  // A new word is only written into a free output register.
  `KBS_ASSERT_NOW(a_emit_free, cmd.emit_bad || cmd.emit_none || cmd.emit_recv || cmd.emit_send, !out_valid_o || out_ready_i, "output word overwritten")
  // While a non-final word is shown the schedule is still running.
  `KBS_ASSERT_NOW(a_busy_mid, out_valid_o && !last_action_o, !in_ready_o, "ready before schedule end")
  // The final send closes its level.
  `KBS_ASSERT_NOW(a_last_rend, out_valid_o && last_action_o && action_kind_o == KIND_SEND, round_end_o, "last send without round end")
  // An accepted request blocks the next one.
  `KBS_ASSERT_NEXT(a_accept_busy, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")

endmodule
